>>> rtl/far_pkg.sv
// far_pkg: shared types and constants for the fraction arithmetic reducer.
// Used by far_div, far_seq and fraction_arith_reduce.
package far_pkg;

    localparam int unsigned OP_W      = 3;
    localparam int unsigned OPD_W     = 16;
    localparam int unsigned WORK_W    = 64;
    localparam int unsigned RES_NUM_W = 33;
    localparam int unsigned RES_DEN_W = 32;

    localparam logic [OP_W-1:0] OP_ADD = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL = 3'd2;
    localparam logic [OP_W-1:0] OP_DIV = 3'd3;
    localparam logic [OP_W-1:0] OP_RED = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic signed [OPD_W-1:0] first_num;
        logic signed [OPD_W-1:0] first_den;
        logic signed [OPD_W-1:0] second_num;
        logic signed [OPD_W-1:0] second_den;
    } t_in;

    typedef struct packed {
        logic signed [RES_NUM_W-1:0] res_num;
        logic signed [RES_DEN_W-1:0] res_den;
        logic                        gcd_zero;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_FORM, S_GCD_GO, S_GCD_WAIT,
        S_DN_GO, S_DN_WAIT, S_DM_GO, S_DM_WAIT, S_DONE
    } t_state;

    // divider request / reply between sequencer and shared divider
    typedef struct packed {
        logic                     go;
        logic signed [WORK_W-1:0] dvd;
        logic signed [WORK_W-1:0] dvs;
    } t_div_req;

    typedef struct packed {
        logic                     done;
        logic signed [WORK_W-1:0] quo;
        logic signed [WORK_W-1:0] rem;
    } t_div_rsp;

endpackage

>>> rtl/far_div.sv
// far_div: iterative signed 64-bit truncating divider, one quotient bit a cycle.
// Depends on far_pkg.
module far_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  far_pkg::t_div_req i_req,
    output far_pkg::t_div_rsp o_rsp
);
    import far_pkg::*;

    logic [WORK_W-1:0]           r_q, n_q;
    logic [WORK_W-1:0]           r_r, n_r;
    logic [WORK_W-1:0]           r_d, n_d;
    logic [$clog2(WORK_W+1)-1:0] r_cnt, n_cnt;
    logic                        r_busy, n_busy, r_done, n_done;
    logic                        r_qneg, n_qneg, r_rneg, n_rneg;
    logic [WORK_W:0]             w_trial;
    logic [WORK_W-1:0]           w_shr;

    // restoring shift-subtract on magnitudes; signs applied at the end
    always_comb begin
        n_q = r_q; n_r = r_r; n_d = r_d; n_cnt = r_cnt;
        n_busy = r_busy; n_done = 1'b0; n_qneg = r_qneg; n_rneg = r_rneg;
        w_shr   = {r_r[WORK_W-2:0], r_q[WORK_W-1]};
        w_trial = {1'b0, w_shr} - {1'b0, r_d};
        if (i_req.go) begin
            n_q    = i_req.dvd[WORK_W-1] ? WORK_W'(-i_req.dvd) : i_req.dvd;
            n_d    = i_req.dvs[WORK_W-1] ? WORK_W'(-i_req.dvs) : i_req.dvs;
            n_r    = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
            n_qneg = i_req.dvd[WORK_W-1] ^ i_req.dvs[WORK_W-1];
            n_rneg = i_req.dvd[WORK_W-1];
        end else if (r_busy) begin
            // remainder high bit may be set only for the 2^63 magnitude case
            if (r_r[WORK_W-1] || !w_trial[WORK_W]) begin
                n_r = w_trial[WORK_W-1:0];
                n_q = {r_q[WORK_W-2:0], 1'b1};
            end else begin
                n_r = w_shr;
                n_q = {r_q[WORK_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == ($clog2(WORK_W+1))'(WORK_W-1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_q <= n_q; r_r <= n_r; r_d <= n_d; r_cnt <= n_cnt;
        r_qneg <= n_qneg; r_rneg <= n_rneg;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_qneg ? -$signed(r_q) : $signed(r_q);
    assign o_rsp.rem  = r_rneg ? -$signed(r_r) : $signed(r_r);
endmodule

>>> rtl/far_seq.sv
// far_seq: sequencer forming cross products, running Euclid and the final
// divisions on the shared divider. Depends on far_pkg.
module far_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [far_pkg::OP_W-1:0]         i_op,
    input  logic signed [far_pkg::OPD_W-1:0] i_a,
    input  logic signed [far_pkg::OPD_W-1:0] i_b,
    input  logic signed [far_pkg::OPD_W-1:0] i_c,
    input  logic signed [far_pkg::OPD_W-1:0] i_d,
    input  far_pkg::t_div_rsp i_rsp,
    output far_pkg::t_div_req o_req,
    output logic              o_busy,
    output logic              o_done,
    output far_pkg::t_out     o_res
);
    import far_pkg::*;

    t_state r_st, n_st;
    logic [OP_W-1:0] r_op;
    logic signed [OPD_W-1:0] r_a, r_b, r_c, r_d;
    logic signed [WORK_W-1:0] r_p0, n_p0, r_p1, n_p1, r_p2, n_p2;
    logic signed [WORK_W-1:0] r_n, n_n, r_m, n_m, r_x, n_x, r_y, n_y;
    logic signed [WORK_W-1:0] r_qn, n_qn;
    logic signed [OPD_W-1:0]   w_ma, w_mb;
    logic signed [2*OPD_W-1:0] w_prod;
    t_out r_res, n_res;

    // single shared multiplier, operands picked by state and op
    always_comb begin
        w_ma = r_a; w_mb = r_d;
        case (r_st)
            S_MUL0: if (r_op == OP_MUL) w_mb = r_c;
            S_MUL1: begin
                // add/sub: c*b, mul: b*d, div: b*c
                w_ma = r_b;
                w_mb = (r_op inside {OP_ADD, OP_SUB, OP_DIV}) ? r_c : r_d;
            end
            S_MUL2: begin
                w_ma = r_b; w_mb = r_d;
            end
            default: ;
        endcase
        w_prod = w_ma * w_mb;
    end

    always_comb begin
        n_st = r_st; n_p0 = r_p0; n_p1 = r_p1; n_p2 = r_p2; n_n = r_n; n_m = r_m;
        n_x = r_x; n_y = r_y; n_qn = r_qn; n_res = r_res;
        o_req = '0;
        o_done = 1'b0;
        case (r_st)
            S_IDLE:   if (i_start) n_st = S_MUL0;
            S_MUL0: begin
                n_p0 = WORK_W'(w_prod);
                n_st = S_MUL1;
            end
            S_MUL1: begin
                n_p1 = WORK_W'(w_prod);
                n_st = (r_op == OP_ADD || r_op == OP_SUB) ? S_MUL2 : S_FORM;
            end
            S_MUL2: begin
                n_p2 = WORK_W'(w_prod);
                n_st = S_FORM;
            end
            S_FORM: begin
                // raw result n/m; b*d comes from the third product for add and subtract
                if (r_op == OP_ADD) begin
                    n_n = r_p0 + r_p1; n_m = r_p2;
                end else if (r_op == OP_SUB) begin
                    n_n = r_p0 - r_p1; n_m = r_p2;
                end else if (r_op == OP_MUL || r_op == OP_DIV) begin
                    n_n = r_p0; n_m = r_p1;
                end else begin
                    n_n = WORK_W'(r_a); n_m = WORK_W'(r_b);
                end
                n_x = n_n; n_y = n_m;
                n_st = S_GCD_GO;
            end
            S_GCD_GO: begin
                if (r_y == '0) begin
                    if (r_x == '0) begin
                        n_res.res_num  = RES_NUM_W'(r_n);
                        n_res.res_den  = RES_DEN_W'(r_m);
                        n_res.gcd_zero = 1'b1;
                        n_st = S_DONE;
                    end else n_st = S_DN_GO;
                end else if (r_y == -64'sd1) begin
                    n_x = r_y; n_y = '0;
                end else begin
                    o_req.go = 1'b1; o_req.dvd = r_x; o_req.dvs = r_y;
                    n_st = S_GCD_WAIT;
                end
            end
            S_GCD_WAIT: if (i_rsp.done) begin
                n_x = r_y; n_y = i_rsp.rem; n_st = S_GCD_GO;
            end
            S_DN_GO: begin
                if (r_x == -64'sd1) begin
                    n_res.res_num  = RES_NUM_W'(-r_n);
                    n_res.res_den  = RES_DEN_W'(-r_m);
                    n_res.gcd_zero = 1'b0;
                    n_st = S_DONE;
                end else begin
                    o_req.go = 1'b1; o_req.dvd = r_n; o_req.dvs = r_x;
                    n_st = S_DN_WAIT;
                end
            end
            S_DN_WAIT: if (i_rsp.done) begin
                n_qn = i_rsp.quo; n_st = S_DM_GO;
            end
            S_DM_GO: begin
                o_req.go = 1'b1; o_req.dvd = r_m; o_req.dvs = r_x;
                n_st = S_DM_WAIT;
            end
            S_DM_WAIT: if (i_rsp.done) begin
                n_res.res_num  = RES_NUM_W'(r_qn);
                n_res.res_den  = RES_DEN_W'(i_rsp.quo);
                n_res.gcd_zero = 1'b0;
                n_st = S_DONE;
            end
            S_DONE: begin
                o_done = 1'b1;
                n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= S_IDLE;
        else          r_st <= n_st;
        if (r_st == S_IDLE && i_start) begin
            r_op <= i_op;
            r_a <= i_a; r_b <= i_b;
            r_c <= i_c; r_d <= i_d;
        end
        r_p0 <= n_p0; r_p1 <= n_p1; r_p2 <= n_p2; r_n <= n_n; r_m <= n_m;
        r_x <= n_x; r_y <= n_y; r_qn <= n_qn; r_res <= n_res;
    end

    assign o_busy = (r_st != S_IDLE);
    assign o_res  = r_res;
endmodule

>>> rtl/fraction_arith_reduce.sv
// fraction_arith_reduce: top level of the fraction arithmetic reducer.
// Depends on far_pkg, far_seq and far_div.
//
// Usage:
//  - Raise start with an input transaction on i_in while busy is low; the
//    transaction is taken at that edge and busy rises the cycle after.
//  - The operation forms exact cross products on one shared multiplier in
//    S_MUL0 and S_MUL1, plus S_MUL2 for the add and subtract denominator.
//  - The fraction is reduced by Euclid on one shared 64-bit divider, one
//    division per remainder step; two more divisions give the result.
//  - When the gcd is -1 or zero, the final divisions are skipped.
//  - The next transaction can be taken the cycle after the result.
//  - The result is shown on o_out for one cycle with o_valid high; the
//    receiver cannot stall, so it must take it then.
//  - When numerator and denominator are both zero, they pass through and
//    gcd_zero is set.
//  - Synchronous active-low reset returns the block to idle.
module fraction_arith_reduce (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  far_pkg::t_in   i_in,
    output logic           o_valid,
    output far_pkg::t_out  o_out
);
    import far_pkg::*;

    t_div_req w_req;
    t_div_rsp w_rsp;

    // sequencer holds the operands and the reduction loop
    far_seq u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_op(i_in.op),
        .i_a(i_in.first_num), .i_b(i_in.first_den),
        .i_c(i_in.second_num), .i_d(i_in.second_den),
        .i_rsp(w_rsp), .o_req(w_req), .o_busy(busy), .o_done(o_valid), .o_res(o_out)
    );

    // shared divider for remainders and final quotients
    far_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp)
    );
endmodule
